// ===== rtl/core/ebs_pkg.sv =====
package ebs_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int NUM_NORMALS  = 49;
  localparam int NRM_W        = 6;
  localparam int SLOT_W       = 7;
  localparam int PROJ_W       = 40;
  localparam int WIDE_W       = 66;
  localparam int ROOT_W       = 34;
  localparam int K_W          = 30;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SET  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW_ENABLE = 1'b1;

  typedef logic signed [31:0]       coord_t;
  typedef logic signed [PROJ_W-1:0] proj_t;
  typedef logic [WIDE_W-1:0]        wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    proj_t  pmin;
    proj_t  pmax;
    point_t qmin;
    point_t qmax;
  } ext_ent_t;

  localparam proj_t PROJ_HI_INIT = {1'b0, {(PROJ_W-1){1'b1}}};
  localparam proj_t PROJ_LO_INIT = {1'b1, {(PROJ_W-1){1'b0}}};
  localparam ext_ent_t EXT_RESET = '{pmin: PROJ_HI_INIT, pmax: PROJ_LO_INIT,
                                     qmin: '0, qmax: '0};

  typedef struct packed {
    logic signed [2:0] x;
    logic signed [2:0] y;
    logic signed [2:0] z;
  } dir_t;

  localparam dir_t NORMAL_DIRS [NUM_NORMALS] = '{
    '{1,0,0},'{0,1,0},'{0,0,1},
    '{1,1,1},'{1,1,-1},'{1,-1,1},'{1,-1,-1},
    '{1,1,0},'{1,-1,0},'{1,0,1},'{1,0,-1},'{0,1,1},'{0,1,-1},
    '{0,1,2},'{0,2,1},'{1,0,2},'{2,0,1},'{1,2,0},'{2,1,0},
    '{0,1,-2},'{0,2,-1},'{1,0,-2},'{2,0,-1},'{1,-2,0},'{2,-1,0},
    '{1,1,2},'{2,1,1},'{1,2,1},'{1,-1,2},'{1,1,-2},'{1,-1,-2},
    '{2,-1,1},'{2,1,-1},'{2,-1,-1},'{1,-2,1},'{1,2,-1},'{1,-2,-1},
    '{2,2,1},'{1,2,2},'{2,1,2},'{2,-2,1},'{2,2,-1},'{2,-2,-1},
    '{1,-2,2},'{1,2,-2},'{1,-2,-2},'{2,-1,2},'{2,1,-2},'{2,-1,-2}
  };

  typedef enum logic [1:0] {
    UOP_DIST2,
    UOP_SQRT,
    UOP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_ADD,
    U_SQRT,
    U_DIV
  } unit_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SMP_RD,
    S_SMP_WR,
    S_PR_RDI,
    S_PR_GETI,
    S_PR_RDJ,
    S_PR_GETJ,
    S_PR_WAIT,
    S_CTR,
    S_CTR_D,
    S_R2_WAIT,
    S_G_RD,
    S_G_GET,
    S_G_D2,
    S_G_SQD,
    S_G_SQR,
    S_G_DIV,
    S_G_MUL,
    S_G_UPD,
    S_G_R2S,
    S_G_R2,
    S_FIN,
    S_FIN_WAIT,
    S_OUT
  } state_t;

  function automatic coord_t axis_of(point_t p, logic [1:0] ax);
    coord_t c;
    case (ax)
      2'd0:    c = p.x;
      2'd1:    c = p.y;
      default: c = p.z;
    endcase
    return c;
  endfunction

  function automatic proj_t proj_of(point_t p, dir_t d);
    proj_t tx;
    proj_t ty;
    proj_t tz;
    tx = proj_t'(proj_t'(p.x) * proj_t'(d.x));
    ty = proj_t'(proj_t'(p.y) * proj_t'(d.y));
    tz = proj_t'(proj_t'(p.z) * proj_t'(d.z));
    return proj_t'(tx + ty + tz);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_count(logic [1:0] ns);
    logic [SLOT_W-1:0] s;
    case (ns)
      2'd0:    s = SLOT_W'(6);
      2'd1:    s = SLOT_W'(14);
      2'd2:    s = SLOT_W'(26);
      default: s = SLOT_W'(98);
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/ebs_if.sv =====
interface ebs_vertex_if;
  logic            valid;
  logic            ready;
  ebs_pkg::coord_t vertex_x;
  ebs_pkg::coord_t vertex_y;
  ebs_pkg::coord_t vertex_z;
  logic            in_sample;
  logic            last_vertex;

  modport source(output valid, vertex_x, vertex_y, vertex_z, in_sample, last_vertex,
                 input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_z, in_sample, last_vertex,
               output ready);
endinterface

interface ebs_sphere_if;
  logic            valid;
  logic            ready;
  ebs_pkg::coord_t center_x;
  ebs_pkg::coord_t center_y;
  ebs_pkg::coord_t center_z;
  logic [30:0]     sphere_radius;

  modport source(output valid, center_x, center_y, center_z, sphere_radius, input ready);
  modport sink(input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

// ===== rtl/core/ebs_unit.sv =====
module ebs_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ebs_pkg::unit_req_t                 req,
  input  ebs_pkg::point_t                    pa,
  input  ebs_pkg::point_t                    pb,
  input  ebs_pkg::wide_t                     wide_in,
  input  logic [ebs_pkg::ROOT_W-1:0]         num,
  input  logic [ebs_pkg::ROOT_W-1:0]         den,
  output logic                               done,
  output ebs_pkg::wide_t                     result
);

  ebs_pkg::unit_state_t st_r, st_nxt;
  logic [1:0]                   ax_r;
  ebs_pkg::wide_t               acc_r;
  ebs_pkg::wide_t               prod_r;
  ebs_pkg::point_t              pa_r;
  ebs_pkg::point_t              pb_r;
  logic [35:0]                  rem_r;
  logic [ebs_pkg::ROOT_W-1:0]   root_r;
  logic [67:0]                  rad_r;
  logic [5:0]                   it_r;
  logic [34:0]                  dv_rem_r;
  logic [ebs_pkg::ROOT_W-1:0]   den_r;
  logic [ebs_pkg::K_W-1:0]      q_r;
  logic                         done_r;
  ebs_pkg::wide_t               res_r;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [36:0]        sq_rem;
  logic [36:0]        sq_trial;
  logic               sq_ge;
  logic [34:0]        dv_t;
  logic               dv_ge;

  always_comb begin
    diff     = 33'(ebs_pkg::axis_of(pa_r, ax_r)) - 33'(ebs_pkg::axis_of(pb_r, ax_r));
    mag      = diff[32] ? 33'(-diff) : 33'(diff);
    sq_rem   = {rem_r[34:0], rad_r[67:66]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = sq_rem >= sq_trial;
    dv_t     = (it_r == 6'd0) ? dv_rem_r : {dv_rem_r[33:0], 1'b0};
    dv_ge    = dv_t >= {1'b0, den_r};
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ebs_pkg::U_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            ebs_pkg::UOP_DIST2: st_nxt = ebs_pkg::U_MUL;
            ebs_pkg::UOP_SQRT:  st_nxt = ebs_pkg::U_SQRT;
            default:            st_nxt = ebs_pkg::U_DIV;
          endcase
        end
      end
      ebs_pkg::U_MUL:  st_nxt = ebs_pkg::U_ADD;
      ebs_pkg::U_ADD:  st_nxt = (ax_r == 2'd2) ? ebs_pkg::U_IDLE : ebs_pkg::U_MUL;
      ebs_pkg::U_SQRT: st_nxt = (it_r == 6'(ebs_pkg::ROOT_W - 1)) ? ebs_pkg::U_IDLE
                                                                    : ebs_pkg::U_SQRT;
      ebs_pkg::U_DIV:  st_nxt = (it_r == 6'(ebs_pkg::K_W - 1)) ? ebs_pkg::U_IDLE
                                                                 : ebs_pkg::U_DIV;
      default:         st_nxt = ebs_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ebs_pkg::U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r != ebs_pkg::U_IDLE) && (st_nxt == ebs_pkg::U_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ebs_pkg::U_IDLE: begin
        pa_r     <= pa;
        pb_r     <= pb;
        acc_r    <= '0;
        ax_r     <= 2'd0;
        rem_r    <= '0;
        root_r   <= '0;
        rad_r    <= {2'b00, wide_in};
        it_r     <= '0;
        dv_rem_r <= {1'b0, num};
        den_r    <= den;
        q_r      <= '0;
      end
      ebs_pkg::U_MUL: begin
        prod_r <= ebs_pkg::WIDE_W'(mag * mag);
      end
      ebs_pkg::U_ADD: begin
        acc_r <= acc_r + prod_r;
        ax_r  <= ax_r + 2'd1;
        if (ax_r == 2'd2) begin
          res_r <= acc_r + prod_r;
        end
      end
      ebs_pkg::U_SQRT: begin
        rem_r  <= sq_ge ? 36'(sq_rem - sq_trial) : sq_rem[35:0];
        root_r <= {root_r[ebs_pkg::ROOT_W-2:0], sq_ge};
        rad_r  <= {rad_r[65:0], 2'b00};
        it_r   <= it_r + 6'd1;
        if (it_r == 6'(ebs_pkg::ROOT_W - 1)) begin
          res_r <= ebs_pkg::WIDE_W'({root_r[ebs_pkg::ROOT_W-2:0], sq_ge});
        end
      end
      ebs_pkg::U_DIV: begin
        dv_rem_r <= dv_ge ? 35'(dv_t - {1'b0, den_r}) : dv_t;
        q_r      <= {q_r[ebs_pkg::K_W-2:0], dv_ge};
        it_r     <= it_r + 6'd1;
        if (it_r == 6'(ebs_pkg::K_W - 1)) begin
          res_r <= ebs_pkg::WIDE_W'({q_r[ebs_pkg::K_W-2:0], dv_ge});
        end
      end
      default: begin
      end
    endcase
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== rtl/core/epos_bounding_sphere.sv =====
// Bounding sphere of a vertex set, built from extremal points on fixed normals.
// Vertices arrive as beats on in_vtx; in_sample marks vertices that take part
// in the extremal search and last_vertex closes the set. The first 4096
// vertices are kept in a 4096-entry store; later ones are dropped from the
// store but still searched. The 98 min/max slots live in one 49-entry memory.
// A sampled vertex reads and writes each of the 49 memory entries in turn.
// After the last vertex the block searches all slot pairs of the normal set
// (up to 4753 pairs), then, if growing is enabled, makes one grow pass over
// the store, bound for vertices outside the sphere by the bit-serial square
// roots and divider of the shared arithmetic unit. One sphere beat follows.
// normal_set and grow_enable are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block itself
// does not enforce it. Reset clears the set, selects 3 normals and enables
// growing. A finished sphere waits in the output register while the next
// set loads; a further sphere waits until out_sph is taken.
module epos_bounding_sphere (
  input  logic                                clk,
  input  logic                                rst_n,
  ebs_vertex_if.sink                          in_vtx,
  ebs_sphere_if.source                        out_sph,
  input  logic                                cfg_we,
  input  logic [ebs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ebs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int EXT_W = $bits(ebs_pkg::ext_ent_t);
  localparam int VTX_W = $bits(ebs_pkg::point_t);

  logic [VTX_W-1:0] sto_mem [ebs_pkg::MAX_VERTICES];
  logic [EXT_W-1:0] ext_mem [ebs_pkg::NUM_NORMALS];

  ebs_pkg::state_t state_r, state_nxt;

  logic [1:0]                      normal_set_r;
  logic                            grow_en_r;
  logic [ebs_pkg::CNT_W-1:0]       count_r;
  logic [ebs_pkg::NUM_NORMALS-1:0] ext_vld_r;
  ebs_pkg::point_t                 v_r;
  logic                            last_r;
  logic [ebs_pkg::NRM_W-1:0]       n_r;
  logic [ebs_pkg::SLOT_W-1:0]      i_r;
  logic [ebs_pkg::SLOT_W-1:0]      j_r;
  ebs_pkg::point_t                 pi_r;
  ebs_pkg::point_t                 pj_r;
  ebs_pkg::point_t                 pbi_r;
  ebs_pkg::point_t                 pbj_r;
  ebs_pkg::wide_t                  best_r;
  ebs_pkg::point_t                 c_r;
  logic [63:0]                     r2_r;
  logic [ebs_pkg::CNT_W-1:0]       g_r;
  logic [ebs_pkg::ROOT_W-1:0]      d_r;
  logic [ebs_pkg::K_W-1:0]         k_r;
  logic [1:0]                      ax_r;
  logic [62:0]                     prod_r;
  logic                            neg_r;
  logic [EXT_W-1:0]                ext_rd_r;
  logic                            ext_rd_vld_r;
  logic [VTX_W-1:0]                sto_rd_r;
  logic [30:0]                     fin_rad_r;
  logic                            out_valid_r;
  ebs_pkg::point_t                 out_c_r;
  logic [30:0]                     out_rad_r;

  ebs_pkg::unit_req_t              ureq;
  ebs_pkg::point_t                 u_pa;
  ebs_pkg::point_t                 u_pb;
  ebs_pkg::wide_t                  u_wide;
  logic [ebs_pkg::ROOT_W-1:0]      u_num;
  logic [ebs_pkg::ROOT_W-1:0]      u_den;
  logic                            u_done;
  ebs_pkg::wide_t                  u_res;

  logic                            in_acc;
  logic [ebs_pkg::NRM_W-1:0]       ext_ra;
  ebs_pkg::ext_ent_t               ext_ent;
  ebs_pkg::ext_ent_t               ext_new;
  ebs_pkg::proj_t                  pr;
  ebs_pkg::point_t                 slot_pt;
  ebs_pkg::point_t                 in_pt;
  ebs_pkg::point_t                 c_mid;
  logic [ebs_pkg::SLOT_W-1:0]      slots;
  logic                            outside;
  logic                            better;
  logic signed [32:0]              gdiff;
  logic [32:0]                     gmag;
  logic [63:0]                     off_sum;
  logic signed [34:0]              c_sum;
  ebs_pkg::coord_t                 c_sat;
  logic                            out_free;

  ebs_unit u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ureq),
    .pa      (u_pa),
    .pb      (u_pb),
    .wide_in (u_wide),
    .num     (u_num),
    .den     (u_den),
    .done    (u_done),
    .result  (u_res)
  );

  always_comb begin
    in_pt    = '{x: in_vtx.vertex_x, y: in_vtx.vertex_y, z: in_vtx.vertex_z};
    in_acc   = in_vtx.valid && (state_r == ebs_pkg::S_IDLE);
    out_free = !out_valid_r || out_sph.ready;
    slots    = ebs_pkg::slot_count(normal_set_r);
    ext_ent  = ext_rd_vld_r ? ebs_pkg::ext_ent_t'(ext_rd_r) : ebs_pkg::EXT_RESET;

    pr      = ebs_pkg::proj_of(v_r, ebs_pkg::NORMAL_DIRS[n_r]);
    ext_new = ext_ent;
    // Strict compares keep the earlier vertex on a tie.
    if (pr < ext_ent.pmin) begin
      ext_new.pmin = pr;
      ext_new.qmin = v_r;
    end
    if (pr > ext_ent.pmax) begin
      ext_new.pmax = pr;
      ext_new.qmax = v_r;
    end

    // Even slots are minima, odd slots maxima.
    slot_pt = (state_r == ebs_pkg::S_PR_GETI) ? (i_r[0] ? ext_ent.qmax : ext_ent.qmin)
                                              : (j_r[0] ? ext_ent.qmax : ext_ent.qmin);
    better  = (u_res > best_r) || ((i_r == '0) && (j_r == ebs_pkg::SLOT_W'(1)));

    c_mid.x = 32'((33'(pbi_r.x) + 33'(pbj_r.x)) >>> 1);
    c_mid.y = 32'((33'(pbi_r.y) + 33'(pbj_r.y)) >>> 1);
    c_mid.z = 32'((33'(pbi_r.z) + 33'(pbj_r.z)) >>> 1);

    outside = u_res > {2'b00, r2_r};

    gdiff   = 33'(ebs_pkg::axis_of(v_r, ax_r)) - 33'(ebs_pkg::axis_of(c_r, ax_r));
    gmag    = gdiff[32] ? 33'(-gdiff) : 33'(gdiff);
    off_sum = {1'b0, prod_r} + 64'(64'd1 << 29);
    c_sum   = neg_r ? 35'(ebs_pkg::axis_of(c_r, ax_r)) - 35'(off_sum[63:30])
                    : 35'(ebs_pkg::axis_of(c_r, ax_r)) + 35'(off_sum[63:30]);
    if (c_sum > 35'sh0_7FFF_FFFF) begin
      c_sat = 32'sh7FFF_FFFF;
    end else if (c_sum < -35'sh0_8000_0000) begin
      c_sat = 32'sh8000_0000;
    end else begin
      c_sat = 32'(c_sum);
    end
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_vtx.ready = (state_r == ebs_pkg::S_IDLE);
    ureq         = '{start: 1'b0, op: ebs_pkg::UOP_DIST2};
    u_pa         = c_r;
    u_pb         = v_r;
    u_wide       = {2'b00, r2_r};
    u_num        = d_r - u_res[ebs_pkg::ROOT_W-1:0];
    u_den        = d_r;
    ext_ra       = n_r;
    unique case (state_r)
      ebs_pkg::S_PR_RDI: ext_ra = i_r[ebs_pkg::SLOT_W-1:1];
      ebs_pkg::S_PR_RDJ: ext_ra = j_r[ebs_pkg::SLOT_W-1:1];
      ebs_pkg::S_PR_GETJ: begin
        ureq = '{start: 1'b1, op: ebs_pkg::UOP_DIST2};
        u_pa = pi_r;
        u_pb = slot_pt;
      end
      ebs_pkg::S_CTR_D: begin
        ureq = '{start: 1'b1, op: ebs_pkg::UOP_DIST2};
        u_pb = pbi_r;
      end
      ebs_pkg::S_G_GET: begin
        ureq = '{start: 1'b1, op: ebs_pkg::UOP_DIST2};
        u_pb = ebs_pkg::point_t'(sto_rd_r);
      end
      ebs_pkg::S_G_D2: begin
        ureq   = '{start: u_done && outside, op: ebs_pkg::UOP_SQRT};
        u_wide = u_res;
      end
      ebs_pkg::S_G_SQD: ureq = '{start: u_done, op: ebs_pkg::UOP_SQRT};
      ebs_pkg::S_G_SQR: ureq = '{start: u_done, op: ebs_pkg::UOP_DIV};
      ebs_pkg::S_G_R2S: ureq = '{start: 1'b1, op: ebs_pkg::UOP_DIST2};
      ebs_pkg::S_FIN:   ureq = '{start: 1'b1, op: ebs_pkg::UOP_SQRT};
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ebs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_vtx.in_sample) begin
            state_nxt = ebs_pkg::S_SMP_RD;
          end else if (in_vtx.last_vertex) begin
            state_nxt = ebs_pkg::S_PR_RDI;
          end
        end
      end
      ebs_pkg::S_SMP_RD: state_nxt = ebs_pkg::S_SMP_WR;
      ebs_pkg::S_SMP_WR: begin
        if (n_r != ebs_pkg::NRM_W'(ebs_pkg::NUM_NORMALS - 1)) begin
          state_nxt = ebs_pkg::S_SMP_RD;
        end else begin
          state_nxt = last_r ? ebs_pkg::S_PR_RDI : ebs_pkg::S_IDLE;
        end
      end
      ebs_pkg::S_PR_RDI:  state_nxt = ebs_pkg::S_PR_GETI;
      ebs_pkg::S_PR_GETI: state_nxt = ebs_pkg::S_PR_RDJ;
      ebs_pkg::S_PR_RDJ:  state_nxt = ebs_pkg::S_PR_GETJ;
      ebs_pkg::S_PR_GETJ: state_nxt = ebs_pkg::S_PR_WAIT;
      ebs_pkg::S_PR_WAIT: begin
        if (u_done) begin
          if (j_r + 1'b1 != slots) begin
            state_nxt = ebs_pkg::S_PR_RDJ;
          end else if (i_r + 2'd2 == slots) begin
            state_nxt = ebs_pkg::S_CTR;
          end else begin
            state_nxt = ebs_pkg::S_PR_RDI;
          end
        end
      end
      ebs_pkg::S_CTR:   state_nxt = ebs_pkg::S_CTR_D;
      ebs_pkg::S_CTR_D: state_nxt = ebs_pkg::S_R2_WAIT;
      ebs_pkg::S_R2_WAIT: begin
        if (u_done) begin
          state_nxt = (grow_en_r && (count_r != '0)) ? ebs_pkg::S_G_RD : ebs_pkg::S_FIN;
        end
      end
      ebs_pkg::S_G_RD:  state_nxt = ebs_pkg::S_G_GET;
      ebs_pkg::S_G_GET: state_nxt = ebs_pkg::S_G_D2;
      ebs_pkg::S_G_D2: begin
        if (u_done) begin
          if (outside) begin
            state_nxt = ebs_pkg::S_G_SQD;
          end else if (g_r + 1'b1 == count_r) begin
            state_nxt = ebs_pkg::S_FIN;
          end else begin
            state_nxt = ebs_pkg::S_G_RD;
          end
        end
      end
      ebs_pkg::S_G_SQD: if (u_done) state_nxt = ebs_pkg::S_G_SQR;
      ebs_pkg::S_G_SQR: if (u_done) state_nxt = ebs_pkg::S_G_DIV;
      ebs_pkg::S_G_DIV: if (u_done) state_nxt = ebs_pkg::S_G_MUL;
      ebs_pkg::S_G_MUL: state_nxt = ebs_pkg::S_G_UPD;
      ebs_pkg::S_G_UPD: state_nxt = (ax_r == 2'd2) ? ebs_pkg::S_G_R2S : ebs_pkg::S_G_MUL;
      ebs_pkg::S_G_R2S: state_nxt = ebs_pkg::S_G_R2;
      ebs_pkg::S_G_R2: begin
        if (u_done) begin
          state_nxt = (g_r + 1'b1 == count_r) ? ebs_pkg::S_FIN : ebs_pkg::S_G_RD;
        end
      end
      ebs_pkg::S_FIN:      state_nxt = ebs_pkg::S_FIN_WAIT;
      ebs_pkg::S_FIN_WAIT: if (u_done) state_nxt = ebs_pkg::S_OUT;
      ebs_pkg::S_OUT:      if (out_free) state_nxt = ebs_pkg::S_IDLE;
      default:             state_nxt = ebs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ebs_pkg::S_IDLE;
      normal_set_r <= 2'd0;
      grow_en_r    <= 1'b1;
      count_r      <= '0;
      ext_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == ebs_pkg::CFG_NORMAL_SET) begin
          normal_set_r <= cfg_data[1:0];
        end else begin
          grow_en_r <= cfg_data[0];
        end
      end
      if (in_acc && (count_r < ebs_pkg::CNT_W'(ebs_pkg::MAX_VERTICES))) begin
        count_r <= count_r + 1'b1;
      end
      if (state_r == ebs_pkg::S_SMP_WR) begin
        ext_vld_r[n_r] <= 1'b1;
      end
      if ((state_r == ebs_pkg::S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        ext_vld_r   <= '0;
      end else if (out_sph.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (in_acc && (count_r < ebs_pkg::CNT_W'(ebs_pkg::MAX_VERTICES))) begin
      sto_mem[count_r[ebs_pkg::ADDR_W-1:0]] <= in_pt;
    end
    sto_rd_r <= sto_mem[g_r[ebs_pkg::ADDR_W-1:0]];
    if (state_r == ebs_pkg::S_SMP_WR) begin
      ext_mem[n_r] <= ext_new;
    end
    ext_rd_r     <= ext_mem[ext_ra];
    ext_rd_vld_r <= ext_vld_r[ext_ra];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ebs_pkg::S_IDLE: begin
        v_r    <= in_pt;
        last_r <= in_vtx.last_vertex;
        n_r    <= '0;
        i_r    <= '0;
        best_r <= '0;
      end
      ebs_pkg::S_SMP_WR: n_r <= n_r + 1'b1;
      ebs_pkg::S_PR_GETI: begin
        pi_r <= slot_pt;
        j_r  <= i_r + 1'b1;
      end
      ebs_pkg::S_PR_GETJ: pj_r <= slot_pt;
      ebs_pkg::S_PR_WAIT: begin
        if (u_done) begin
          if (better) begin
            best_r <= u_res;
            pbi_r  <= pi_r;
            pbj_r  <= pj_r;
          end
          if (j_r + 1'b1 != slots) begin
            j_r <= j_r + 1'b1;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
      end
      ebs_pkg::S_CTR: c_r <= c_mid;
      ebs_pkg::S_R2_WAIT: begin
        if (u_done) begin
          r2_r <= (u_res[65:64] != 2'b00) ? '1 : u_res[63:0];
        end
        g_r <= '0;
      end
      ebs_pkg::S_G_GET: v_r <= ebs_pkg::point_t'(sto_rd_r);
      ebs_pkg::S_G_D2: begin
        if (u_done && !outside) begin
          g_r <= g_r + 1'b1;
        end
      end
      ebs_pkg::S_G_SQD: if (u_done) d_r <= u_res[ebs_pkg::ROOT_W-1:0];
      ebs_pkg::S_G_DIV: begin
        if (u_done) begin
          k_r  <= u_res[ebs_pkg::K_W-1:0];
          ax_r <= 2'd0;
        end
      end
      ebs_pkg::S_G_MUL: begin
        prod_r <= 63'(gmag * k_r);
        neg_r  <= gdiff[32];
      end
      ebs_pkg::S_G_UPD: begin
        unique case (ax_r)
          2'd0:    c_r.x <= c_sat;
          2'd1:    c_r.y <= c_sat;
          default: c_r.z <= c_sat;
        endcase
        ax_r <= ax_r + 2'd1;
      end
      ebs_pkg::S_G_R2: begin
        if (u_done) begin
          r2_r <= (u_res[65:64] != 2'b00) ? '1 : u_res[63:0];
          g_r  <= g_r + 1'b1;
        end
      end
      ebs_pkg::S_FIN_WAIT: begin
        if (u_done) begin
          fin_rad_r <= (u_res[ebs_pkg::ROOT_W-1:31] != '0) ? '1 : u_res[30:0];
        end
      end
      ebs_pkg::S_OUT: begin
        if (out_free) begin
          out_c_r   <= c_r;
          out_rad_r <= fin_rad_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_sph.valid         = out_valid_r;
  assign out_sph.center_x      = out_c_r.x;
  assign out_sph.center_y      = out_c_r.y;
  assign out_sph.center_z      = out_c_r.z;
  assign out_sph.sphere_radius = out_rad_r;

endmodule

// ===== verif/tb_epos_bounding_sphere.sv =====
module tb_epos_bounding_sphere;
  import ebs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  STORE_DEPTH = 4096;
  localparam int  SETTLE      = 400;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    coord_t      cx;
    coord_t      cy;
    coord_t      cz;
    logic [30:0] rad;
  } sphere_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ebs_vertex_if vtx ();
  ebs_sphere_if sph ();

  epos_bounding_sphere DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vtx   (vtx.sink),
    .out_sph  (sph.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state of the vertex set.
  longint       store_pt [STORE_DEPTH][3];
  int           store_cnt;
  longint       ext_pt [2*NUM_NORMALS][3];
  longint       ext_proj [2*NUM_NORMALS];
  longint       ctr [3];
  logic [63:0]  rad_sq;
  logic [1:0]   cur_normal_set;
  logic         cur_grow;

  sphere_t      sphere_q [$];
  int           fails;
  longint       cycles;
  bit           no_idle;
  int           hold_req;

  function automatic logic [65:0] sq_dist(longint ax, longint ay, longint az,
                                          longint bx, longint by, longint bz);
    logic [65:0] acc;
    longint      d [3];
    logic [63:0] m;
    d = '{ax - bx, ay - by, az - bz};
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      m = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
      acc = acc + {2'b0, m} * {2'b0, m};
    end
    return acc;
  endfunction

  function automatic logic [33:0] floor_root(logic [65:0] v);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'b0, c} * {34'b0, c} <= {2'b0, v}) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat64(logic [65:0] v);
    return (v[65:64] != 2'b0) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
  endfunction

  function automatic void clear_set();
    store_cnt = 0;
    for (int i = 0; i < 2*NUM_NORMALS; i++) begin
      ext_pt[i] = '{0, 0, 0};
      ext_proj[i] = (i & 1) ? -(longint'(1) << 39) : (longint'(1) << 39) - 1;
    end
    ctr = '{0, 0, 0};
    rad_sq = '0;
  endfunction

  function automatic void grow_over(longint vx, longint vy, longint vz);
    logic [65:0] d2;
    logic [63:0] d;
    logic [63:0] r;
    logic [63:0] k;
    logic [63:0] mag;
    logic [63:0] off;
    longint      v [3];
    longint      diff;
    longint      c;
    v = '{vx, vy, vz};
    d2 = sq_dist(vx, vy, vz, ctr[0], ctr[1], ctr[2]);
    if (!(d2 > {2'b0, rad_sq})) return;
    d = 64'(floor_root(d2));
    r = 64'(floor_root({2'b0, rad_sq}));
    k = ((d - r) << 29) / d;
    for (int i = 0; i < 3; i++) begin
      diff = v[i] - ctr[i];
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      off = (mag * k + (64'd1 << 29)) >> 30;
      c = (diff < 0) ? ctr[i] - longint'(off) : ctr[i] + longint'(off);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      ctr[i] = c;
    end
    rad_sq = sat64(sq_dist(ctr[0], ctr[1], ctr[2], vx, vy, vz));
  endfunction

  // Works out the sphere that closes a set, or just absorbs the vertex.
  function automatic void absorb_vertex(coord_t x, coord_t y, coord_t z,
                                        logic smp, logic last);
    longint      p [3];
    longint      pr;
    int          slots;
    int          bi;
    int          bj;
    logic [65:0] best;
    logic [65:0] s;
    logic [33:0] rt;
    sphere_t     e;
    p = '{longint'(x), longint'(y), longint'(z)};
    if (store_cnt < STORE_DEPTH) begin
      store_pt[store_cnt] = p;
      store_cnt++;
    end
    if (smp) begin
      for (int n = 0; n < NUM_NORMALS; n++) begin
        pr = longint'(NORMAL_DIRS[n].x) * p[0] + longint'(NORMAL_DIRS[n].y) * p[1]
           + longint'(NORMAL_DIRS[n].z) * p[2];
        if (pr < ext_proj[2*n]) begin
          ext_proj[2*n] = pr;
          ext_pt[2*n] = p;
        end
        if (pr > ext_proj[2*n+1]) begin
          ext_proj[2*n+1] = pr;
          ext_pt[2*n+1] = p;
        end
      end
    end
    if (!last) return;
    slots = int'(slot_count(cur_normal_set));
    bi = 0;
    bj = 1;
    best = sq_dist(ext_pt[0][0], ext_pt[0][1], ext_pt[0][2],
                   ext_pt[1][0], ext_pt[1][1], ext_pt[1][2]);
    for (int i = 0; i < slots; i++)
      for (int j = i + 1; j < slots; j++) begin
        s = sq_dist(ext_pt[i][0], ext_pt[i][1], ext_pt[i][2],
                    ext_pt[j][0], ext_pt[j][1], ext_pt[j][2]);
        if (s > best) begin
          best = s;
          bi = i;
          bj = j;
        end
      end
    for (int i = 0; i < 3; i++) ctr[i] = (ext_pt[bi][i] + ext_pt[bj][i]) >>> 1;
    rad_sq = sat64(sq_dist(ctr[0], ctr[1], ctr[2],
                           ext_pt[bi][0], ext_pt[bi][1], ext_pt[bi][2]));
    if (cur_grow)
      for (int i = 0; i < store_cnt; i++)
        grow_over(store_pt[i][0], store_pt[i][1], store_pt[i][2]);
    rt = floor_root({2'b0, rad_sq});
    e.cx = coord_t'(ctr[0]);
    e.cy = coord_t'(ctr[1]);
    e.cz = coord_t'(ctr[2]);
    e.rad = (rt > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : rt[30:0];
    sphere_q.push_back(e);
    clear_set();
  endfunction

  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic smp, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.vertex_x <= x;
    vtx.vertex_y <= y;
    vtx.vertex_z <= z;
    vtx.in_sample <= smp;
    vtx.last_vertex <= last;
    do @(posedge clk); while (!vtx.ready);
    absorb_vertex(x, y, z, smp, last);
  endtask

  task automatic drain();
    vtx.valid <= 1'b0;
    while (sphere_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NORMAL_SET) cur_normal_set = val;
    else cur_grow = val[0];
  endtask

  function automatic coord_t rand_coord(int spread);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return coord_t'($urandom);
      default: return coord_t'($urandom_range(0, 2*spread)) - coord_t'(spread);
    endcase
  endfunction

  task automatic send_set(int len, int smp_pct, int spread);
    for (int i = 0; i < len; i++)
      send_vertex(rand_coord(spread), rand_coord(spread), rand_coord(spread),
                  $urandom_range(1, 100) <= smp_pct, i == len - 1);
  endtask

  task automatic test_directed();
    write_reg(CFG_NORMAL_SET, 2'd0);
    write_reg(CFG_GROW_ENABLE, 2'd1);
    // A lone sampled vertex, then a set with no sampled vertex at all.
    send_vertex(32'sd65536, -32'sd131072, 32'sd7, 1'b1, 1'b1);
    send_vertex(32'sd1000, 32'sd2000, -32'sd3000, 1'b0, 1'b0);
    send_vertex(-32'sd5000, 32'sd0, 32'sd4000, 1'b0, 1'b1);
    // Opposite corners of the coordinate range push the radius to saturation.
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b1);
    // Duplicated points make ties in both projections and pair distances.
    send_vertex(32'sd100, 32'sd100, 32'sd100, 1'b1, 1'b0);
    send_vertex(32'sd100, 32'sd100, 32'sd100, 1'b1, 1'b0);
    send_vertex(-32'sd100, -32'sd100, -32'sd100, 1'b1, 1'b0);
    send_vertex(-32'sd100, -32'sd100, -32'sd100, 1'b1, 1'b1);
    // Vertices far outside an initial sphere force growth, clamped at the edge.
    send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send_vertex(32'sd10, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send_vertex(32'sh7FFF_0000, -32'sd5, 32'sh8000_1000, 1'b0, 1'b0);
    send_vertex(-32'sd1, -32'sd1, -32'sd1, 1'b0, 1'b1);
    write_reg(CFG_GROW_ENABLE, 2'd0);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send_vertex(32'sd10, 32'sd0, 32'sd0, 1'b1, 1'b0);
    send_vertex(32'sd999999, 32'sd0, 32'sd0, 1'b0, 1'b1);
    write_reg(CFG_GROW_ENABLE, 2'd1);
  endtask

  task automatic test_normal_sets();
    for (int ns = 0; ns < 4; ns++)
      for (int g = 0; g < 2; g++) begin
        write_reg(CFG_NORMAL_SET, 2'(ns));
        write_reg(CFG_GROW_ENABLE, 2'(g));
        send_set($urandom_range(4, 10), 80, 1 << 20);
      end
    write_reg(CFG_GROW_ENABLE, 2'd1);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_NORMAL_SET, 2'd0);
    hold_req = 3000;
    for (int s = 0; s < 8; s++) send_set($urandom_range(2, 6), 20, 1 << 16);
    drain();
  endtask

  task automatic test_random();
    int      done;
    int      len;
    done = 0;
    while (done < 1500) begin
      if ($urandom_range(0, 5) == 0) begin
        // The widest normal set costs a long pair search; keep it rare.
        write_reg(CFG_NORMAL_SET, ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2)));
        write_reg(CFG_GROW_ENABLE, 2'($urandom_range(0, 1)));
      end
      no_idle = ($urandom_range(0, 4) == 0);
      len = $urandom_range(1, 16);
      send_set(len, $urandom_range(0, 100), 1 << $urandom_range(4, 30));
      done += len;
    end
    no_idle = 1'b0;
    drain();
  endtask

  // Sphere checker and receiver stalls.
  initial begin
    int      stall;
    sphere_t e;
    sph.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        sph.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sph.ready <= 1'b1;
      do @(posedge clk); while (!sph.valid);
      if (sphere_q.size() == 0) begin
        $display("%0t: unexpected sphere beat c=(%0d,%0d,%0d) r=%0d", $time,
                 sph.center_x, sph.center_y, sph.center_z, sph.sphere_radius);
        fails++;
      end else begin
        e = sphere_q.pop_front();
        if (sph.center_x !== e.cx) begin
          $display("%0t: center_x expected %0d actual %0d", $time, e.cx, sph.center_x);
          fails++;
        end
        if (sph.center_y !== e.cy) begin
          $display("%0t: center_y expected %0d actual %0d", $time, e.cy, sph.center_y);
          fails++;
        end
        if (sph.center_z !== e.cz) begin
          $display("%0t: center_z expected %0d actual %0d", $time, e.cz, sph.center_z);
          fails++;
        end
        if (sph.sphere_radius !== e.rad) begin
          $display("%0t: sphere_radius expected %0d actual %0d", $time, e.rad,
                   sph.sphere_radius);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    fails = 0;
    cycles = 0;
    no_idle = 1'b0;
    hold_req = 0;
    cur_normal_set = 2'd0;
    cur_grow = 1'b1;
    clear_set();
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.vertex_z = '0;
    vtx.in_sample = 1'b0;
    vtx.last_vertex = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_normal_sets();
    test_backpressure();
    test_random();
    drain();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
